// File: design/nid_pkg.sv
// ============================================================================
// nid_pkg
// Shared types and constants for the netpbm image decoder.
// ============================================================================
package nid_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_SMP = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_READ   = 2'd2;

    // Format kinds, taken from the digit after the magic.
    localparam logic [2:0] FMT_PBM_ASCII = 3'd1;
    localparam logic [2:0] FMT_PGM_ASCII = 3'd2;
    localparam logic [2:0] FMT_PPM_ASCII = 3'd3;
    localparam logic [2:0] FMT_PBM_RAW   = 3'd4;
    localparam logic [2:0] FMT_PGM_RAW   = 3'd5;
    localparam logic [2:0] FMT_PPM_RAW   = 3'd6;

    // Characters of interest.
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  channel_count;
        logic [7:0]  sample_value;
        logic [1:0]  channel_index;
        logic [1:0]  error_code;
        logic        last;
    } out_item_t;

    // Parser phase.
    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_KIND,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_DATA,
        PH_IDLE
    } phase_t;

    // Sequencer state.
    typedef enum logic [3:0] {
        SQ_WAIT,
        SQ_DECODE,
        SQ_FINISH,
        SQ_EOF_END,
        SQ_DIV_GO,
        SQ_DIV_WAIT,
        SQ_SMP_PUSH,
        SQ_HDR_PUSH,
        SQ_ERR_PUSH
    } seq_t;

    // Where the sequencer goes after a sample or a pushed result.
    typedef enum logic [1:0] {
        RT_WAIT,
        RT_EOF,
        RT_BITS
    } ret_t;

    // Source of a raw sample.
    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_BIT,
        SRC_DIGIT,
        SRC_ACC
    } src_t;

    typedef struct packed {
        logic       load_in;
        logic       set_kind;
        logic       digit;
        logic       comment_set;
        logic       comment_clr;
        logic       num_clr;
        logic       clr_flags;
        logic       wr_width;
        logic       wr_height;
        logic       wr_maxval;
        logic       maxval_one;
        logic       enter_data;
        logic       bit_init;
        logic       bit_dec;
        logic       div_start;
        src_t       src;
        logic       push_hdr;
        logic       push_smp;
        logic       push_err;
        logic [1:0] err;
    } cmd_t;

    typedef struct packed {
        logic       eof;
        logic       is_p;
        logic       kind_ok;
        logic       is_digit;
        logic       is_hash;
        logic       is_nl;
        logic       is_01;
        logic       in_number;
        logic       in_comment;
        logic [2:0] kind;
        logic       dims_bad;
        logic       acc_bad;
        logic       div_busy;
        logic       out_ready;
        logic       smp_last;
        logic       smp_wrap;
        logic       bit_zero;
    } sts_t;

endpackage

// File: design/nid_datapath.sv
// ============================================================================
// nid_datapath
// Byte register, number accumulator, header registers, raster counters,
// sample scaling divider and the result register.
// ============================================================================
module nid_datapath
    import nid_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  byte_data,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    localparam int DVD_W     = DIM_BITS + 8;
    localparam int DIV_STEPS = DIM_BITS + 8;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int EXT_W     = (DIM_BITS + 1 > 16) ? DIM_BITS + 1 : 16;
    localparam int MUL_W     = DIM_BITS + 5;

    logic [7:0]          byte_reg;
    logic                eof_reg;
    logic [DIM_BITS:0]   acc_reg;
    logic                in_number_reg;
    logic                in_comment_reg;
    logic [2:0]          kind_reg;
    logic [1:0]          cc_reg;
    logic [DIM_BITS:0]   width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIM_BITS-1:0] maxval_reg;
    logic [DIM_BITS-1:0] col_reg;
    logic [DIM_BITS-1:0] row_reg;
    logic [1:0]          chan_reg;
    logic [2:0]          bit_reg;

    logic [DIM_BITS-1:0] rem_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [7:0]          q_reg;
    logic [CNT_W-1:0]    cnt_reg;

    out_item_t           out_reg;
    out_item_t           out_next;
    logic                out_valid_reg;

    logic [3:0]          digit_val;
    logic [MUL_W-1:0]    acc_mul;
    logic [MUL_W-1:0]    acc_cap;
    logic [DIM_BITS:0]   acc_next;
    logic                bitmap;
    logic [DIM_BITS-1:0] s_raw;
    logic [DIM_BITS-1:0] s_val;
    logic [DVD_W-1:0]    dividend;
    logic [DIM_BITS:0]   shifted;
    logic [DIM_BITS:0]   rem_sub;
    logic                ge;
    logic [2:0]          chan_inc;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;
    logic                chan_wrap;
    logic                col_wrap;
    logic [EXT_W-1:0]    width_ext;
    logic [EXT_W-1:0]    height_ext;
    logic                out_ready;

    assign digit_val = byte_reg[3:0];
    assign acc_cap   = MUL_W'(1) << DIM_BITS;
    assign acc_mul   = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) + MUL_W'(digit_val);

    always_comb
    begin
        if (!in_number_reg)
        begin
            acc_next = (DIM_BITS + 1)'(digit_val);
        end
        else if (acc_reg[DIM_BITS])
        begin
            acc_next = acc_reg;
        end
        else if (acc_mul > acc_cap)
        begin
            acc_next = acc_cap[DIM_BITS:0];
        end
        else
        begin
            acc_next = acc_mul[DIM_BITS:0];
        end
    end

    assign bitmap = (kind_reg == FMT_PBM_ASCII) || (kind_reg == FMT_PBM_RAW);

    always_comb
    begin
        case (cmd.src)
            SRC_BYTE:  s_raw = DIM_BITS'(byte_reg);
            SRC_BIT:   s_raw = DIM_BITS'(byte_reg[bit_reg]);
            SRC_DIGIT: s_raw = DIM_BITS'(byte_reg[0]);
            SRC_ACC:   s_raw = acc_reg[DIM_BITS] ? '1 : acc_reg[DIM_BITS-1:0];
            default:   s_raw = '0;
        endcase
        if (bitmap)
        begin
            s_val = (s_raw >= maxval_reg) ? '0 : maxval_reg - s_raw;
        end
        else
        begin
            s_val = s_raw;
        end
    end

    // s * 255 as (s << 8) - s.
    assign dividend = {s_val, 8'h00} - DVD_W'(s_val);

    // One restoring step per cycle; only the low eight quotient bits are kept.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = shifted - {1'b0, maxval_reg};
    assign ge      = shifted >= {1'b0, maxval_reg};

    assign chan_inc  = 3'(chan_reg) + 3'd1;
    assign col_inc   = (DIM_BITS + 1)'(col_reg) + 1'b1;
    assign row_inc   = (DIM_BITS + 1)'(row_reg) + 1'b1;
    assign chan_wrap = chan_inc >= 3'(cc_reg);
    assign col_wrap  = chan_wrap && (col_inc >= width_reg);

    assign width_ext  = EXT_W'(width_reg);
    assign height_ext = EXT_W'(height_reg);
    assign out_ready  = !out_valid_reg || !result_stall;

    always_comb
    begin
        sts            = '0;
        sts.eof        = eof_reg;
        sts.is_p       = byte_reg == CH_P;
        sts.kind_ok    = (byte_reg >= CH_1) && (byte_reg <= CH_6);
        sts.is_digit   = (byte_reg >= CH_0) && (byte_reg <= CH_9);
        sts.is_hash    = byte_reg == CH_HASH;
        sts.is_nl      = byte_reg == CH_NL;
        sts.is_01      = (byte_reg == CH_0) || (byte_reg == CH_1);
        sts.in_number  = in_number_reg;
        sts.in_comment = in_comment_reg;
        sts.kind       = kind_reg;
        sts.acc_bad    = (acc_reg == '0) || acc_reg[DIM_BITS];
        sts.dims_bad   = sts.acc_bad || (width_reg == '0) || width_reg[DIM_BITS];
        sts.div_busy   = cnt_reg != '0;
        sts.out_ready  = out_ready;
        sts.smp_last   = col_wrap && (row_inc >= {1'b0, height_reg});
        sts.smp_wrap   = col_wrap;
        sts.bit_zero   = bit_reg == 3'd0;
    end

    // Payload of the next result.
    always_comb
    begin
        out_next               = '0;
        out_next.image_width   = width_ext[15:0];
        out_next.image_height  = height_ext[15:0];
        out_next.channel_count = cc_reg;
        if (cmd.push_hdr)
        begin
            out_next.kind = KIND_HDR;
        end
        else if (cmd.push_smp)
        begin
            out_next.kind          = KIND_SMP;
            out_next.sample_value  = q_reg;
            out_next.channel_index = chan_reg;
            out_next.last          = sts.smp_last;
        end
        else
        begin
            out_next.kind          = KIND_ERR;
            out_next.image_width   = '0;
            out_next.image_height  = '0;
            out_next.channel_count = '0;
            out_next.error_code    = cmd.err;
            out_next.last          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg       <= '0;
            eof_reg        <= 1'b0;
            acc_reg        <= '0;
            in_number_reg  <= 1'b0;
            in_comment_reg <= 1'b0;
            kind_reg       <= '0;
            cc_reg         <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            chan_reg       <= '0;
            bit_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                byte_reg <= byte_data.in_byte;
                eof_reg  <= byte_data.end_of_file;
            end
            if (cmd.set_kind)
            begin
                kind_reg <= byte_reg[2:0];
                cc_reg   <= ((byte_reg[2:0] == FMT_PPM_ASCII) ||
                             (byte_reg[2:0] == FMT_PPM_RAW)) ? 2'd3 : 2'd1;
            end
            if (cmd.digit)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.clr_flags || cmd.num_clr || cmd.set_kind)
            begin
                in_number_reg <= 1'b0;
            end
            else if (cmd.digit)
            begin
                in_number_reg <= 1'b1;
            end
            if (cmd.clr_flags || cmd.comment_clr || cmd.set_kind)
            begin
                in_comment_reg <= 1'b0;
            end
            else if (cmd.comment_set)
            begin
                in_comment_reg <= 1'b1;
            end
            if (cmd.wr_width)
            begin
                width_reg <= acc_reg;
            end
            if (cmd.wr_height)
            begin
                height_reg <= acc_reg[DIM_BITS-1:0];
            end
            if (cmd.wr_maxval)
            begin
                maxval_reg <= acc_reg[DIM_BITS-1:0];
            end
            else if (cmd.maxval_one)
            begin
                maxval_reg <= DIM_BITS'(1);
            end
            if (cmd.bit_init)
            begin
                bit_reg <= 3'd7;
            end
            else if (cmd.bit_dec)
            begin
                bit_reg <= bit_reg - 3'd1;
            end
            if (cmd.div_start)
            begin
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.enter_data)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                chan_reg <= '0;
            end
            else if (cmd.push_smp)
            begin
                if (chan_wrap)
                begin
                    chan_reg <= '0;
                    if (col_wrap)
                    begin
                        col_reg <= '0;
                        row_reg <= row_inc[DIM_BITS-1:0];
                    end
                    else
                    begin
                        col_reg <= col_inc[DIM_BITS-1:0];
                    end
                end
                else
                begin
                    chan_reg <= chan_inc[1:0];
                end
            end
            if (cmd.push_hdr || cmd.push_smp || cmd.push_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_sub[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
            dvd_reg <= dvd_reg << 1;
            q_reg   <= {q_reg[6:0], ge};
        end
        if (cmd.push_hdr || cmd.push_smp || cmd.push_err)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// File: design/nid_controller.sv
// ============================================================================
// nid_controller
// Parser phase and sequencer that steps the datapath through each byte.
// ============================================================================
module nid_controller
    import nid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    output logic byte_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    seq_t       seq_reg, seq_next;
    phase_t     phase_reg, phase_next;
    ret_t       ret_reg, ret_next;
    logic [1:0] err_reg, err_next;
    seq_t       ret_seq;
    logic       do_text;
    logic       text_eof;

    assign ret_seq  = (ret_reg == RT_EOF) ? SQ_EOF_END : SQ_WAIT;
    assign text_eof = (phase_reg == PH_WIDTH) || (phase_reg == PH_HEIGHT) ||
                      (phase_reg == PH_MAXVAL) ||
                      ((phase_reg == PH_DATA) &&
                       ((sts.kind == FMT_PGM_ASCII) || (sts.kind == FMT_PPM_ASCII)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SQ_WAIT;
            phase_reg <= PH_MAGIC;
            ret_reg   <= RT_WAIT;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            ret_reg   <= ret_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        ret_next   = ret_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.err    = err_reg;
        do_text    = 1'b0;
        byte_stall = seq_reg != SQ_WAIT;

        case (seq_reg)
            SQ_WAIT:
            begin
                if (byte_valid)
                begin
                    cmd.load_in = 1'b1;
                    seq_next    = SQ_DECODE;
                end
            end

            SQ_DECODE:
            begin
                seq_next = SQ_WAIT;
                ret_next = RT_WAIT;
                if (sts.eof)
                begin
                    if (text_eof && sts.in_number)
                    begin
                        ret_next = RT_EOF;
                        seq_next = SQ_FINISH;
                    end
                    else
                    begin
                        seq_next = SQ_EOF_END;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_MAGIC:
                        begin
                            if (sts.is_p)
                            begin
                                phase_next = PH_KIND;
                            end
                            else
                            begin
                                phase_next    = PH_IDLE;
                                cmd.clr_flags = 1'b1;
                                err_next      = ERR_FORMAT;
                                seq_next      = SQ_ERR_PUSH;
                            end
                        end
                        PH_KIND:
                        begin
                            if (sts.kind_ok)
                            begin
                                cmd.set_kind = 1'b1;
                                phase_next   = PH_WIDTH;
                            end
                            else
                            begin
                                phase_next    = PH_IDLE;
                                cmd.clr_flags = 1'b1;
                                err_next      = ERR_FORMAT;
                                seq_next      = SQ_ERR_PUSH;
                            end
                        end
                        PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                        begin
                            do_text = 1'b1;
                        end
                        PH_DATA:
                        begin
                            if (sts.kind == FMT_PBM_RAW)
                            begin
                                cmd.bit_init = 1'b1;
                                ret_next     = RT_BITS;
                                seq_next     = SQ_DIV_GO;
                            end
                            else if ((sts.kind == FMT_PGM_RAW) || (sts.kind == FMT_PPM_RAW))
                            begin
                                cmd.div_start = 1'b1;
                                cmd.src       = SRC_BYTE;
                                seq_next      = SQ_DIV_WAIT;
                            end
                            else
                            begin
                                do_text = 1'b1;
                            end
                        end
                        default:
                        begin
                            seq_next = SQ_WAIT;
                        end
                    endcase
                end

                // Text characters: comments, digits and number separators.
                if (do_text)
                begin
                    if (sts.in_comment && !sts.is_nl)
                    begin
                        seq_next = SQ_WAIT;
                    end
                    else if (!sts.in_comment && sts.is_hash)
                    begin
                        cmd.comment_set = 1'b1;
                    end
                    else
                    begin
                        if (sts.in_comment)
                        begin
                            cmd.comment_clr = 1'b1;
                        end
                        if ((phase_reg == PH_DATA) && (sts.kind == FMT_PBM_ASCII))
                        begin
                            if (sts.is_01)
                            begin
                                cmd.div_start = 1'b1;
                                cmd.src       = SRC_DIGIT;
                                seq_next      = SQ_DIV_WAIT;
                            end
                        end
                        else if (sts.is_digit)
                        begin
                            cmd.digit = 1'b1;
                        end
                        else if (sts.in_number)
                        begin
                            seq_next = SQ_FINISH;
                        end
                    end
                end
            end

            SQ_FINISH:
            begin
                cmd.num_clr = 1'b1;
                seq_next    = ret_seq;
                case (phase_reg)
                    PH_WIDTH:
                    begin
                        cmd.wr_width = 1'b1;
                        phase_next   = PH_HEIGHT;
                    end
                    PH_HEIGHT:
                    begin
                        cmd.wr_height = 1'b1;
                        if (sts.dims_bad)
                        begin
                            phase_next    = PH_IDLE;
                            cmd.clr_flags = 1'b1;
                            err_next      = ERR_FORMAT;
                            seq_next      = SQ_ERR_PUSH;
                        end
                        else if ((sts.kind == FMT_PBM_ASCII) || (sts.kind == FMT_PBM_RAW))
                        begin
                            cmd.maxval_one = 1'b1;
                            cmd.enter_data = 1'b1;
                            phase_next     = PH_DATA;
                            seq_next       = SQ_HDR_PUSH;
                        end
                        else
                        begin
                            phase_next = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL:
                    begin
                        cmd.wr_maxval = 1'b1;
                        if (sts.acc_bad)
                        begin
                            phase_next    = PH_IDLE;
                            cmd.clr_flags = 1'b1;
                            err_next      = ERR_FORMAT;
                            seq_next      = SQ_ERR_PUSH;
                        end
                        else
                        begin
                            cmd.enter_data = 1'b1;
                            phase_next     = PH_DATA;
                            seq_next       = SQ_HDR_PUSH;
                        end
                    end
                    PH_DATA:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.src       = SRC_ACC;
                        seq_next      = SQ_DIV_WAIT;
                    end
                    default:
                    begin
                        seq_next = ret_seq;
                    end
                endcase
            end

            SQ_EOF_END:
            begin
                phase_next    = PH_MAGIC;
                cmd.clr_flags = 1'b1;
                ret_next      = RT_WAIT;
                if (phase_reg == PH_DATA)
                begin
                    err_next = ERR_READ;
                    seq_next = SQ_ERR_PUSH;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    err_next = ERR_FORMAT;
                    seq_next = SQ_ERR_PUSH;
                end
                else
                begin
                    seq_next = SQ_WAIT;
                end
            end

            SQ_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_BIT;
                seq_next      = SQ_DIV_WAIT;
            end

            SQ_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    seq_next = SQ_SMP_PUSH;
                end
            end

            SQ_SMP_PUSH:
            begin
                if (sts.out_ready)
                begin
                    cmd.push_smp = 1'b1;
                    if (sts.smp_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                    if ((ret_reg == RT_BITS) && !sts.smp_last && !sts.smp_wrap &&
                        !sts.bit_zero)
                    begin
                        cmd.bit_dec = 1'b1;
                        seq_next    = SQ_DIV_GO;
                    end
                    else
                    begin
                        seq_next = ret_seq;
                    end
                end
            end

            SQ_HDR_PUSH:
            begin
                if (sts.out_ready)
                begin
                    cmd.push_hdr = 1'b1;
                    seq_next     = ret_seq;
                end
            end

            SQ_ERR_PUSH:
            begin
                if (sts.out_ready)
                begin
                    cmd.push_err = 1'b1;
                    seq_next     = ret_seq;
                end
            end

            default:
            begin
                seq_next = SQ_WAIT;
            end
        endcase
    end

endmodule

// File: design/netpbm_image_decoder.sv
// A byte that yields no result goes through an accept and a decode step. A
// sample also goes through the one-bit-per-cycle restoring divider that
// scales each sample by maxval. A packed bitmap byte yields up to eight
// samples, each through the divider. Reset (rst_n low, asynchronous)
// returns the parser to await the magic 'P'.
// ============================================================================
// netpbm_image_decoder
// Decodes a netpbm file byte stream into a header result, scaled 8-bit
// samples in raster order, or an error result.
// ============================================================================
module netpbm_image_decoder
    import nid_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_data,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    // The controller owns the parser phase and the per-byte sequence; it
    // stalls the input while a byte is being worked on. The datapath owns
    // every number: the latched byte, the decimal accumulator, header
    // values, raster counters, the divider and the result register. The
    // result register is separate from the input side, so a new byte is
    // taken while a finished transaction waits to be taken downstream.
    cmd_t cmd;
    sts_t sts;

    nid_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    nid_datapath #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_data    (byte_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: design/nid_checker.sv
// ============================================================================
// nid_checker
// Port-level checks for the netpbm image decoder, bound to the top level.
// ============================================================================
module nid_checker
    import nid_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_stall,
    input in_item_t  byte_data,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result_data
);

    // A stalled result transaction stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result dropped or changed while stalled");

    // An accepted byte carries known data, and the next cycle works on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall |-> !$isunknown(byte_data) ##1 byte_stall)
        else $error("byte transaction unknown or not followed by a stall");

    // Every error result ends the image and carries a real code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == KIND_ERR) |->
            result_data.last && (result_data.error_code != ERR_NONE))
        else $error("error result without last or code");

    // A sample names an existing channel and carries no error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == KIND_SMP) |->
            (result_data.channel_index < result_data.channel_count) &&
            (result_data.error_code == ERR_NONE))
        else $error("sample result with bad channel or error code");

endmodule

bind netpbm_image_decoder nid_checker u_nid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// File: sim/netpbm_image_decoder_test.sv
`timescale 1ns / 100ps
// ============================================================================
// netpbm_image_decoder_test
// Self-checking bench: a short directed table, then randomly built netpbm
// files of every kind (well formed, truncated, corrupted), checked field by
// field against a behavioral decoder kept inside the bench.
// ============================================================================
module netpbm_image_decoder_test
    import nid_pkg::*;
;

    localparam int DIMW      = 16;
    localparam int DIM_LIMIT = (1 << DIMW) - 1;
    localparam int NUM_SAT   = DIM_LIMIT + 1;
    localparam int SETTLE    = 400;    // wait after the expected results run out
    localparam int WDOG_MAX  = 6000;   // cycles with no transaction at all
    localparam int ITEM_GOAL = 320;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_data;

    always #4 clk = ~clk;

    netpbm_image_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_data(result_data)
    );

    // ------------------------------------------------------------------------
    // Decoder model state. Header numbers keep one extra bit so that values
    // above the 16-bit range can still be seen and rejected.
    // ------------------------------------------------------------------------
    phase_t      m_phase;
    logic [2:0]  m_fmt;
    logic [16:0] m_acc;
    logic        m_in_num;
    logic        m_in_cmt;
    logic [16:0] m_width;
    logic [16:0] m_height;
    logic [16:0] m_maxval;
    logic [16:0] m_col;
    logic [16:0] m_row;
    logic [1:0]  m_chans;
    logic [1:0]  m_chan_pos;

    out_item_t   expected_results[$];
    out_item_t   fresh[$];          // results from the byte just decoded
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          files_built = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    task automatic model_reset();
        m_phase = PH_MAGIC; m_fmt = '0; m_acc = '0; m_in_num = 0; m_in_cmt = 0;
        m_width = '0; m_height = '0; m_maxval = '0; m_col = '0; m_row = '0;
        m_chans = '0; m_chan_pos = '0;
    endtask

    function automatic logic is_bitmap();
        return m_fmt == FMT_PBM_ASCII || m_fmt == FMT_PBM_RAW;
    endfunction

    task automatic add_result(logic [1:0] k, logic [7:0] v, logic [1:0] ch,
                              logic [1:0] e, logic l);
        out_item_t r;
        logic dims;
        dims = (k != KIND_ERR);
        r.kind          = k;
        r.image_width   = dims ? m_width[15:0] : '0;
        r.image_height  = dims ? m_height[15:0] : '0;
        r.channel_count = dims ? m_chans : '0;
        r.sample_value  = v;
        r.channel_index = ch;
        r.error_code    = e;
        r.last          = l;
        fresh.push_back(r);
    endtask

    task automatic raise_error(logic [1:0] code);
        m_phase = PH_IDLE;
        m_in_num = 0;
        m_in_cmt = 0;
        add_result(KIND_ERR, '0, '0, code, 1'b1);
    endtask

    task automatic scale_sample(int unsigned raw);
        int unsigned s, v;
        logic [1:0] ch;
        logic fin;
        s = raw;
        ch = m_chan_pos;
        if (is_bitmap())
            s = (s >= m_maxval) ? 0 : m_maxval - s;
        v = (m_maxval != 0) ? (s * 255) / m_maxval : 0;
        fin = (m_chan_pos + 1 >= m_chans) && (m_col + 1 >= m_width)
              && (m_row + 1 >= m_height);
        m_chan_pos++;
        if (m_chan_pos >= m_chans)
        begin
            m_chan_pos = 0;
            m_col++;
            if (m_col >= m_width)
            begin
                m_col = 0;
                m_row++;
            end
        end
        if (fin)
            m_phase = PH_IDLE;
        add_result(KIND_SMP, v[7:0], ch, ERR_NONE, fin);
    endtask

    task automatic start_data();
        m_col = 0; m_row = 0; m_chan_pos = 0;
        m_phase = PH_DATA;
        add_result(KIND_HDR, '0, '0, ERR_NONE, 1'b0);
    endtask

    task automatic close_number(logic [16:0] v);
        m_in_num = 0;
        case (m_phase)
            PH_WIDTH:
            begin
                m_width = v;
                m_phase = PH_HEIGHT;
            end
            PH_HEIGHT:
            begin
                m_height = v;
                if (m_width == 0 || m_width > DIM_LIMIT || m_height == 0
                    || m_height > DIM_LIMIT)
                    raise_error(ERR_FORMAT);
                else if (is_bitmap())
                begin
                    m_maxval = 17'd1;
                    start_data();
                end
                else
                    m_phase = PH_MAXVAL;
            end
            PH_MAXVAL:
            begin
                m_maxval = v;
                if (v == 0 || v > DIM_LIMIT)
                    raise_error(ERR_FORMAT);
                else
                    start_data();
            end
            PH_DATA:
                scale_sample(v > DIM_LIMIT ? DIM_LIMIT : v);
            default: ;
        endcase
    endtask

    task automatic text_byte(logic [7:0] b);
        int unsigned grown;
        if (m_in_cmt)
        begin
            if (b != CH_NL)
                return;
            m_in_cmt = 0;
        end
        else if (b == CH_HASH)
        begin
            m_in_cmt = 1;
            return;
        end
        if (m_phase == PH_DATA && m_fmt == FMT_PBM_ASCII)
        begin
            if (b == CH_0 || b == CH_1)
                scale_sample(b - CH_0);
            return;
        end
        if (b >= CH_0 && b <= CH_9)
        begin
            if (!m_in_num)
            begin
                m_in_num = 1;
                m_acc = 17'(b - CH_0);
            end
            else if (m_acc < NUM_SAT)
            begin
                grown = m_acc * 10 + (b - CH_0);
                m_acc = (grown > NUM_SAT) ? 17'(NUM_SAT) : 17'(grown);
            end
            return;
        end
        if (m_in_num)
            close_number(m_acc);
    endtask

    // Works out every result that one accepted byte causes, into fresh.
    task automatic decode_byte(in_item_t it);
        logic texty;
        fresh.delete();
        if (it.end_of_file)
        begin
            texty = m_phase inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL}
                    || (m_phase == PH_DATA
                        && (m_fmt == FMT_PGM_ASCII || m_fmt == FMT_PPM_ASCII));
            if (texty && m_in_num)
                close_number(m_acc);
            if (m_phase == PH_DATA)
                raise_error(ERR_READ);
            else if (m_phase != PH_IDLE)
                raise_error(ERR_FORMAT);
            m_phase = PH_MAGIC;
            m_in_num = 0;
            m_in_cmt = 0;
            return;
        end
        case (m_phase)
            PH_MAGIC:
                if (it.in_byte == CH_P) m_phase = PH_KIND;
                else raise_error(ERR_FORMAT);
            PH_KIND:
                if (it.in_byte >= CH_1 && it.in_byte <= CH_6)
                begin
                    m_fmt = 3'(it.in_byte - CH_0);
                    m_chans = (m_fmt == FMT_PPM_ASCII || m_fmt == FMT_PPM_RAW) ? 2'd3 : 2'd1;
                    m_in_num = 0;
                    m_in_cmt = 0;
                    m_phase = PH_WIDTH;
                end
                else
                    raise_error(ERR_FORMAT);
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                text_byte(it.in_byte);
            PH_DATA:
                if (m_fmt == FMT_PBM_RAW)
                begin
                    // Packed bits, MSB first; the rest of a row's last byte is padding.
                    for (int i = 7; i >= 0; i--)
                    begin
                        scale_sample(it.in_byte[i]);
                        if (m_phase != PH_DATA || m_col == 0)
                            break;
                    end
                end
                else if (m_fmt == FMT_PGM_RAW || m_fmt == FMT_PPM_RAW)
                    scale_sample(it.in_byte);
                else
                    text_byte(it.in_byte);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Checking. Results are sampled at the falling edge and counted at the
    // next rising edge, so nothing depends on event order at the edge.
    // ------------------------------------------------------------------------
    task automatic report(string what, int got, int want);
        mismatches++;
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    logic      res_take = 0, byte_take = 0;
    out_item_t res_seen;
    int        quiet_cycles = 0;

    always @(negedge clk)
    begin
        res_take  = result_valid && !result_stall;
        byte_take = byte_valid && !byte_stall;
        res_seen  = result_data;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && res_take)
        begin
            if (expected_results.size() == 0)
                report("unexpected result, kind", res_seen.kind, -1);
            else
            begin
                want = expected_results.pop_front();
                if (res_seen.kind != want.kind)
                    report("kind", res_seen.kind, want.kind);
                if (res_seen.image_width != want.image_width)
                    report("image_width", res_seen.image_width, want.image_width);
                if (res_seen.image_height != want.image_height)
                    report("image_height", res_seen.image_height, want.image_height);
                if (res_seen.channel_count != want.channel_count)
                    report("channel_count", res_seen.channel_count, want.channel_count);
                if (res_seen.sample_value != want.sample_value)
                    report("sample_value", res_seen.sample_value, want.sample_value);
                if (res_seen.channel_index != want.channel_index)
                    report("channel_index", res_seen.channel_index, want.channel_index);
                if (res_seen.error_code != want.error_code)
                    report("error_code", res_seen.error_code, want.error_code);
                if (res_seen.last != want.last)
                    report("last", res_seen.last, want.last);
            end
            results_seen++;
        end
        // The receiver stalls at random at the current rate.
        result_stall <= ($urandom_range(99) < recv_idle);
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n || res_take || byte_take)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("timeout: no transaction for %0d cycles", WDOG_MAX);
            $display("netpbm_image_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. A byte is driven at the rising edge; the decision whether it
    // was taken is made from the stall seen at the falling edge before.
    // A typed expectation, where given, replaces the model's single result.
    // ------------------------------------------------------------------------
    task automatic send_byte(in_item_t it, logic typed = 0, out_item_t typed_res = '0);
        logic go;
        while ($urandom_range(99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= it;
        do
        begin
            @(negedge clk);
            go = !byte_stall;
            @(posedge clk);
        end while (!go);
        decode_byte(it);
        if (typed)
        begin
            if (fresh.size() != 1)
                report("typed row, result count", fresh.size(), 1);
            expected_results.push_back(typed_res);
        end
        else
            foreach (fresh[i]) expected_results.push_back(fresh[i]);
        bytes_sent++;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // File builder for the random part.
    // ------------------------------------------------------------------------
    in_item_t file_q[$];

    task automatic put_char(logic [7:0] c);
        file_q.push_back('{in_byte: c, end_of_file: 1'b0});
    endtask

    task automatic put_sep();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            put_char(CH_HASH);
            repeat ($urandom_range(3)) put_char(8'($urandom_range(32, 126)));
            put_char(CH_NL);
        end
        else if (pick < 4) put_char(CH_NL);
        else if (pick < 6) put_char(8'h09);
        else put_char(8'h20);
    endtask

    task automatic put_number(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0) put_char(CH_0);   // leading zero
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    function automatic int unsigned pick_dim();
        int p;
        p = $urandom_range(39);
        if (p == 0) return 0;
        if (p == 1) return 70000;
        if (p == 2) return 999999;
        return $urandom_range(1, 4);
    endfunction

    task automatic build_file();
        int kind, w, h, mv, n, p;
        file_q.delete();
        p = $urandom_range(19);
        if (p == 0)
        begin
            // Plain noise.
            repeat ($urandom_range(1, 4)) put_char(8'($urandom));
        end
        else
        begin
            kind = (p == 1) ? $urandom_range(0, 9) : $urandom_range(1, 6);
            put_char((p == 2) ? 8'($urandom) : CH_P);
            put_char(8'(CH_0 + kind));
            w = pick_dim();
            h = ($urandom_range(9) == 0) ? pick_dim() : $urandom_range(1, 3);
            p = $urandom_range(9);
            mv = (p < 3) ? 255 : (p < 5) ? DIM_LIMIT : (p < 6) ? 1
               : (p == 6) ? ($urandom_range(4) == 0 ? 0 : 70000) : $urandom_range(2, 1000);
            put_sep(); put_number(w); put_sep(); put_number(h);
            if (!(kind == 1 || kind == 4))
            begin
                put_sep(); put_number(mv);
            end
            put_sep();
            if (w <= 4 && h <= 3 && w > 0 && h > 0)
            begin
                n = w * h * ((kind == 3 || kind == 6) ? 3 : 1);
                if (kind == 4) n = ((w + 7) / 8) * h;
                for (int i = 0; i < n; i++)
                    case (kind)
                        1:
                        begin
                            put_char(8'($urandom_range(CH_0, CH_1)));
                            if ($urandom_range(2) == 0) put_sep();
                        end
                        2, 3:
                        begin
                            p = $urandom_range(15);
                            put_number(p == 0 ? 99999 : p == 1 ? mv + 3
                                       : $urandom_range(0, mv > 0 ? mv : 1));
                            put_sep();
                        end
                        default: put_char(8'($urandom));
                    endcase
                if ($urandom_range(3) == 0) put_char(8'($urandom));   // trailing junk
            end
            // Truncate now and then for early end of file.
            if ($urandom_range(6) == 0)
                repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
        end
        file_q.push_back('{in_byte: 8'($urandom), end_of_file: 1'b1});
        files_built++;
    endtask

    // ------------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        logic       eof;
        logic       typed;
        out_item_t  res;
    } row_t;

    localparam out_item_t FORMAT_ERR = '{kind: KIND_ERR, error_code: ERR_FORMAT,
                                         last: 1'b1, default: '0};
    localparam out_item_t HDR_2X1 = '{kind: KIND_HDR, image_width: 16'd2,
                                      image_height: 16'd1, channel_count: 2'd1,
                                      default: '0};
    localparam out_item_t NONE = '0;

    row_t directed[$] = '{
        '{8'h58, 0, 1, FORMAT_ERR},       // bad magic
        '{8'hFF, 1, 0, NONE},             // end of file after an error
        '{CH_P,  0, 0, NONE},
        '{8'h37, 0, 1, FORMAT_ERR},       // kind digit out of range
        '{8'h00, 1, 0, NONE},
        '{CH_P,  0, 0, NONE},
        '{CH_1,  0, 0, NONE},             // ASCII bitmap, 2 x 1
        '{8'h20, 0, 0, NONE},
        '{8'h32, 0, 0, NONE},
        '{8'h20, 0, 0, NONE},
        '{CH_1,  0, 0, NONE},
        '{CH_NL, 0, 1, HDR_2X1},
        '{CH_0,  0, 0, NONE},
        '{CH_1,  0, 0, NONE},             // last sample
        '{8'h00, 1, 0, NONE},
        '{CH_P,  0, 0, NONE},
        '{CH_6,  0, 0, NONE},             // raw RGB, with a comment
        '{CH_HASH, 0, 0, NONE},
        '{CH_9,  0, 0, NONE},
        '{CH_NL, 0, 0, NONE},
        '{CH_1,  0, 0, NONE},
        '{8'h20, 0, 0, NONE},
        '{CH_1,  0, 0, NONE},
        '{8'h20, 0, 0, NONE},
        '{8'hFF, 1, 0, NONE}              // end of file inside the header
    };

    initial
    begin
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte('{in_byte: directed[i].b, end_of_file: directed[i].eof},
                      directed[i].typed, directed[i].res);
        drain();

        // Three idle profiles, each ended by a full drain of the results.
        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle = (phase_no == 0) ? 20 : (phase_no == 1) ? 50 : 0;
            recv_idle = (phase_no == 0) ? 50 : (phase_no == 1) ? 20 : 0;
            while (bytes_sent < 25 + (ITEM_GOAL * (phase_no + 1)) / 3)
            begin
                build_file();
                foreach (file_q[i]) send_byte(file_q[i]);
            end
            drain();
        end

        $display("covered %0d bytes in %0d random files, %0d results checked",
                 bytes_sent, files_built, results_seen);
        if (mismatches == 0)
            $display("netpbm_image_decoder verification clean");
        else
            $display("netpbm_image_decoder verification failed");
        $finish;
    end

endmodule
